[sv/potms_pkg.sv]
// Package for the power-of-ten mantissa scaler: table of 96-bit powers of ten,
// shared types and pure helper functions. No dependencies.
package potms_pkg;

    localparam int FullSteps = 13;

    typedef struct packed {
        logic [31:0] m2;
        logic [31:0] m1;
        logic [31:0] m0;
        logic [15:0] bexp;
    } ten_entry_t;

    // Index i holds ten to the power two to the (12 - i).
    function automatic ten_entry_t ten_entry(input logic [3:0] idx);
        ten_entry_t t;
        case (idx)
            4'd0:  t = '{32'hC4605202, 32'h8A20979A, 32'hC94C1540, 16'd13606};
            4'd1:  t = '{32'h9E8B3B5D, 32'hC53D5DE4, 32'hA74D28CE, 16'd6803};
            4'd2:  t = '{32'hC9767586, 32'h81750C17, 32'h650D3D29, 16'd3401};
            4'd3:  t = '{32'hE319A0AE, 32'hA60E91C6, 32'hCC655C55, 16'd1700};
            4'd4:  t = '{32'hAA7EEBFB, 32'h9DF9DE8D, 32'hDDBB901C, 16'd850};
            4'd5:  t = '{32'h93BA47C9, 32'h80E98CDF, 32'hC66F336C, 16'd425};
            4'd6:  t = '{32'hC2781F49, 32'hFFCFA6D5, 32'h3CBF6B72, 16'd212};
            4'd7:  t = '{32'h9DC5ADA8, 32'h2B70B59D, 32'hF0200000, 16'd106};
            4'd8:  t = '{32'h8E1BC9BF, 32'h04000000, 32'h00000000, 16'd53};
            4'd9:  t = '{32'hBEBC2000, 32'h00000000, 32'h00000000, 16'd26};
            4'd10: t = '{32'h9C400000, 32'h00000000, 32'h00000000, 16'd13};
            4'd11: t = '{32'hC8000000, 32'h00000000, 32'h00000000, 16'd6};
            4'd12: t = '{32'hA0000000, 32'h00000000, 32'h00000000, 16'd3};
            default: t = '0;
        endcase
        return t;
    endfunction

    // Leading zeros of a 64-bit word (64 when zero).
    function automatic logic [6:0] lead64(input logic [63:0] x);
        logic [6:0] c;
        logic       found;
        c = 7'd64;
        found = 1'b0;
        for (int b = 63; b >= 0; b--) begin
            if (x[b] && !found) begin
                c = 7'(63 - b);
                found = 1'b1;
            end
        end
        return c;
    endfunction

    // Payload carried along the pipeline between stages.
    typedef struct packed {
        logic [127:0] w;
        logic [12:0]  n;
        logic [15:0]  e;
    } potms_item_t;

    // Partial products of one multiply, registered before the column sums.
    typedef struct packed {
        logic [63:0] a0b1, a0b2, a1b0, a2b0, a1b1, a1b2, a2b1, a2b2;
    } potms_pp_t;

endpackage

[sv/potms_mul_stage.sv]
// One table multiply and normalization, cut into three register stages:
// partial products, column sums with shift-by-31, normalization.
// Depends on potms_pkg.
module potms_mul_stage #(
    parameter int STEP_IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic                  in_valid,
    input  potms_pkg::potms_item_t in_item,
    output logic                  out_valid,
    output potms_pkg::potms_item_t out_item
);
    import potms_pkg::*;

    localparam ten_entry_t Tab = ten_entry(4'(STEP_IDX));
    localparam int BitIdx = FullSteps - 1 - STEP_IDX;

    logic        v1_reg, v2_reg, v3_reg;
    potms_item_t i1_reg, i2_reg, i3_reg;
    logic        use1_reg, use2_reg;
    potms_pp_t   pp_reg, pp_next;
    logic        use_next;

    // Stage 1: partial products.
    always_comb begin
        pp_next.a0b1 = 64'(in_item.w[31:0])  * 64'(Tab.m1);
        pp_next.a0b2 = 64'(in_item.w[31:0])  * 64'(Tab.m2);
        pp_next.a1b0 = 64'(in_item.w[63:32]) * 64'(Tab.m0);
        pp_next.a2b0 = 64'(in_item.w[95:64]) * 64'(Tab.m0);
        pp_next.a1b1 = 64'(in_item.w[63:32]) * 64'(Tab.m1);
        pp_next.a1b2 = 64'(in_item.w[63:32]) * 64'(Tab.m2);
        pp_next.a2b1 = 64'(in_item.w[95:64]) * 64'(Tab.m1);
        pp_next.a2b2 = 64'(in_item.w[95:64]) * 64'(Tab.m2);
        use_next     = in_item.n[BitIdx];
    end

    // Stage 2: truncated column sums, then shift right by 31 with sticky.
    logic [63:0]  c0, c1, c2;
    logic [127:0] prod, shr, w2_next;
    always_comb begin
        c0 = 64'(pp_reg.a0b1[63:32]) + 64'(pp_reg.a1b0[63:32])
           + 64'(pp_reg.a0b2[31:0]) + 64'(pp_reg.a2b0[31:0]) + 64'(pp_reg.a1b1[31:0]);
        c1 = 64'(c0[63:32]) + 64'(pp_reg.a0b2[63:32]) + 64'(pp_reg.a2b0[63:32])
           + 64'(pp_reg.a1b1[63:32]) + 64'(pp_reg.a1b2[31:0]) + 64'(pp_reg.a2b1[31:0]);
        c2 = 64'(c1[63:32]) + 64'(pp_reg.a1b2[63:32]) + 64'(pp_reg.a2b1[63:32])
           + pp_reg.a2b2;
        prod = {c2, c1[31:0], c0[31:0]};
        shr  = prod >> 31;
        shr[0] = shr[0] | (|prod[30:0]);
        w2_next = use1_reg ? shr : i1_reg.w;
    end

    // Stage 3: normalization.
    logic [127:0] w3;
    logic [31:0]  rnd;
    logic [63:0]  top;
    logic [6:0]   s;
    logic [5:0]   rs;
    logic [15:0]  e3;
    logic [127:0] sh_r;
    always_comb begin
        w3   = i2_reg.w;
        e3   = i2_reg.e;
        rnd  = 32'((w3[31:0] > 32'h80000000)
                   || (w3[31:0] == 32'h80000000 && w3[32]));
        top  = w3[95:32] + 64'(rnd);
        s    = '0;
        rs   = '0;
        sh_r = '0;
        if (use2_reg) begin
            e3 = i2_reg.e + Tab.bexp;
            if (|w3[127:96]) begin
                rs   = 6'(7'd32 - lead64({w3[127:96], 32'hFFFFFFFF}));
                sh_r = w3 >> rs;
                sh_r[0] = sh_r[0] | (|(w3[31:0] & ((32'd1 << rs) - 32'd1)));
                w3   = sh_r;
                e3   = e3 + 16'(rs);
            end else if (!(top == '0 && w3[31:0] == '0)) begin
                s  = (top != '0) ? lead64(top) : 7'(7'd64 + lead64({w3[31:0], 32'hFFFFFFFF}));
                w3 = w3 << s;
                e3 = e3 - 16'(s);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pp_reg   <= pp_next;
            use1_reg <= use_next;
            i1_reg   <= in_item;
            use2_reg <= use1_reg;
            i2_reg   <= '{w: w2_next, n: i1_reg.n, e: i1_reg.e};
            i3_reg   <= '{w: w3, n: i2_reg.n, e: e3};
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = i3_reg;

`ifndef SYNTHESIS
    a_v_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> v2_reg == $past(v1_reg))
        else $error("valid lost between product stages");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(v3_reg) && $stable(i3_reg))
        else $error("stage changed during stall");
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && v2_reg && !use2_reg |=> i3_reg.w == $past(i2_reg.w))
        else $error("unused step altered value");
`endif
endmodule

[sv/power_of_ten_mantissa_scaler.sv]
// Top level of the power-of-ten mantissa scaler: chain of table-multiply
// stages with a two-entry skid buffer at the output.
// Depends on potms_pkg and potms_mul_stage.
//
//  channel | tdata fields (low bit up)                          | tuser
//  s_      | value_hi[63:0], value_lo[127:64], power_exponent   | -
//  m_      | result_hi[63:0], result_lo[127:64], exponent_adjust | -
//
// Each table step registers its products, column sums and normalization in turn,
// then the result enters the skid buffer; one item is accepted per cycle while the second skid slot is free.
// Reset clears all valid bits. When the skid buffer fills, the pipeline
// freezes as a whole and nothing is lost or repeated.
module power_of_ten_mantissa_scaler #(
    parameter int TABLE_STEPS = 13
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // value_hi, value_lo, power_exponent
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata    // result_hi, result_lo, exponent_adjust
);
    import potms_pkg::*;

    localparam int First = FullSteps - TABLE_STEPS;

    logic        advance;
    logic        sv_valid [TABLE_STEPS+1];
    potms_item_t sv_item  [TABLE_STEPS+1];

    logic        q0v_reg, q1v_reg;
    potms_item_t q0_reg, q1_reg;

    // Pipeline moves while the second skid slot is free.
    assign advance  = !q1v_reg;
    assign s_tready = advance;

    assign sv_valid[0] = s_tvalid;
    assign sv_item[0]  = '{w: {s_tdata[63:0], s_tdata[127:64]},
                           n: s_tdata[140:128], e: 16'd0};

    for (genvar g = 0; g < TABLE_STEPS; g++) begin : g_step
        potms_mul_stage #(.STEP_IDX(First + g)) u_step (
            .aclk, .aresetn, .advance,
            .in_valid (sv_valid[g]),   .in_item (sv_item[g]),
            .out_valid(sv_valid[g+1]), .out_item(sv_item[g+1])
        );
    end

    logic pop, push;
    assign pop  = q0v_reg && m_tready;
    assign push = advance && sv_valid[TABLE_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q0v_reg <= 1'b0;
            q1v_reg <= 1'b0;
        end else begin
            if (pop) begin
                q0v_reg <= q1v_reg || push;
                q1v_reg <= q1v_reg && push;
            end else if (push) begin
                q0v_reg <= 1'b1;
                q1v_reg <= q0v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            q0_reg <= q1v_reg ? q1_reg : sv_item[TABLE_STEPS];
            if (push) q1_reg <= sv_item[TABLE_STEPS];
        end else if (push) begin
            if (q0v_reg) q1_reg <= sv_item[TABLE_STEPS];
            else         q0_reg <= sv_item[TABLE_STEPS];
        end
    end

    assign m_tvalid = q0v_reg;
    assign m_tdata  = {q0_reg.e, q0_reg.w[63:0], q0_reg.w[127:64]};

`ifndef SYNTHESIS
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        q1v_reg |-> q0v_reg) else $error("skid slots out of order");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q1v_reg |-> !s_tready) else $error("accepted while skid full");
    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        q0v_reg && !m_tready |=> q0v_reg && $stable(q0_reg))
        else $error("held result changed");
`endif
endmodule

[verif/tb_power_of_ten_mantissa_scaler.sv]
// Testbench for power_of_ten_mantissa_scaler: drives value/exponent transfers and
// checks every result against an in-bench predictor of the table scaling.
// Depends on the RTL top level only.
`timescale 1ns / 100ps

module tb_power_of_ten_mantissa_scaler;

    localparam int TableSteps = 13;
    localparam int WatchLimit = 20000;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [12:0] pexp;
    } scale_req_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] eadj;
    } scale_res_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;

    scale_req_t pending_reqs[$];
    scale_res_t expected_results[$];
    int         send_idle_pct;
    int         recv_stall_pct;
    int         error_count;
    int         quiet_cycles;

    power_of_ten_mantissa_scaler #(.TABLE_STEPS(TableSteps)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [95:0] table_mant(input int i);
        case (i)
            0:  return 96'hC4605202_8A20979A_C94C1540;
            1:  return 96'h9E8B3B5D_C53D5DE4_A74D28CE;
            2:  return 96'hC9767586_81750C17_650D3D29;
            3:  return 96'hE319A0AE_A60E91C6_CC655C55;
            4:  return 96'hAA7EEBFB_9DF9DE8D_DDBB901C;
            5:  return 96'h93BA47C9_80E98CDF_C66F336C;
            6:  return 96'hC2781F49_FFCFA6D5_3CBF6B72;
            7:  return 96'h9DC5ADA8_2B70B59D_F0200000;
            8:  return 96'h8E1BC9BF_04000000_00000000;
            9:  return 96'hBEBC2000_00000000_00000000;
            10: return 96'h9C400000_00000000_00000000;
            11: return 96'hC8000000_00000000_00000000;
            default: return 96'hA0000000_00000000_00000000;
        endcase
    endfunction

    function automatic int table_bexp(input int i);
        int exps[13] = '{13606, 6803, 3401, 1700, 850, 425, 212, 106, 53, 26, 13, 6, 3};
        return exps[i];
    endfunction

    function automatic int zeros_above(input logic [63:0] x, input int width);
        for (int b = width - 1; b >= 0; b--)
            if (x[b]) return width - 1 - b;
        return width;
    endfunction

    // Right shift with bits lost from the bottom word folded into bit 0.
    function automatic logic [127:0] sticky_shr(input logic [127:0] v, input int n);
        logic [127:0] r;
        r = v;
        while (n >= 32) begin
            r = {32'h0, r[127:33], r[32] | (|r[31:0])};
            n -= 32;
        end
        if (n > 0) begin
            logic lost;
            lost = |(r[31:0] & ((32'h1 << n) - 1));
            r = r >> n;
            r[0] = r[0] | lost;
        end
        return r;
    endfunction

    function automatic scale_res_t predict_scaled(input scale_req_t rq);
        logic [127:0] w;
        logic [63:0]  a0, a1, a2, b0, b1, b2;
        logic [63:0]  c0, c1, c2, top;
        logic [95:0]  m;
        logic         rnd;
        int           e, s;
        scale_res_t   res;
        w = {rq.hi, rq.lo};
        e = 0;
        for (int i = 13 - TableSteps; i < 13; i++) begin
            if (rq.pexp[12 - i]) begin
                m = table_mant(i);
                a0 = w[31:0]; a1 = w[63:32]; a2 = w[95:64];
                b0 = m[31:0]; b1 = m[63:32]; b2 = m[95:64];
                c0 = ((a0 * b1) >> 32) + ((a1 * b0) >> 32) + (a0 * b2 & 64'hFFFFFFFF)
                   + (a2 * b0 & 64'hFFFFFFFF) + (a1 * b1 & 64'hFFFFFFFF);
                c1 = (c0 >> 32) + ((a0 * b2) >> 32) + ((a2 * b0) >> 32) + ((a1 * b1) >> 32)
                   + (a1 * b2 & 64'hFFFFFFFF) + (a2 * b1 & 64'hFFFFFFFF);
                c2 = (c1 >> 32) + ((a1 * b2) >> 32) + ((a2 * b1) >> 32) + a2 * b2;
                w = sticky_shr({c2, c1[31:0], c0[31:0]}, 31);
                e += table_bexp(i);
                if (w[127:96] != 0) begin
                    s = zeros_above({32'h0, w[127:96]}, 32);
                    w = sticky_shr(w, 32 - s);
                    e -= s - 32;
                end else begin
                    // Leading-zero count is taken from the rounded top 64 bits.
                    rnd = (w[31:0] > 32'h80000000) ||
                          (w[31:0] == 32'h80000000 && w[32]);
                    top = w[95:32] + 64'(rnd);
                    if (!(top == 0 && w[31:0] == 0)) begin
                        s = (top != 0) ? zeros_above(top, 64)
                                       : zeros_above({32'h0, w[31:0]}, 32) + 64;
                        w = w << s;
                        e -= s;
                    end
                end
            end
        end
        res.hi = w[127:64];
        res.lo = w[63:0];
        res.eadj = 16'(e);
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = 64'(1) << $urandom_range(0, 63);
            2: v = ~(v >> $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_req(input logic [63:0] hi, input logic [63:0] lo,
                             input logic [12:0] pexp);
        scale_req_t rq;
        rq.hi = hi;
        rq.lo = lo;
        rq.pexp = pexp;
        pending_reqs.push_back(rq);
    endtask

    // Driver: sender idles at the current rate; tvalid stays high until accepted.
    // The front of the queue is the transfer on the bus until it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_results.push_back(predict_scaled(pending_reqs.pop_front()));
            if (pending_reqs.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                scale_req_t nx;
                nx = pending_reqs[0];
                s_tvalid <= 1'b1;
                s_tdata <= {3'b000, nx.pexp, nx.lo, nx.hi};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (m_tvalid && m_tready) begin
                scale_res_t exp_res;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: %h", $realtime, m_tdata);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[63:0] !== exp_res.hi) begin
                        $display("%0t: result_hi expected %h actual %h", $realtime,
                                 exp_res.hi, m_tdata[63:0]);
                        error_count++;
                    end
                    if (m_tdata[127:64] !== exp_res.lo) begin
                        $display("%0t: result_lo expected %h actual %h", $realtime,
                                 exp_res.lo, m_tdata[127:64]);
                        error_count++;
                    end
                    if (m_tdata[143:128] !== exp_res.eadj) begin
                        $display("%0t: exponent_adjust expected %h actual %h", $realtime,
                                 exp_res.eadj, m_tdata[143:128]);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WatchLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int phase_pct[4][2] = '{'{0, 0}, '{72, 0}, '{0, 72}, '{6, 6}};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        quiet_cycles = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, all ones, exponent zero, single table steps, dropped top word.
        queue_req(64'h0, 64'h0, 13'h1FFF);
        queue_req(64'h0, 64'h0, 13'h0);
        queue_req('1, '1, 13'h0);
        queue_req('1, '1, 13'h1FFF);
        queue_req(64'hFFFFFFFF_00000000, 64'h0, 13'h1);
        queue_req(64'h0, 64'h1, 13'h1);
        queue_req(64'h0, 64'h80000000, 13'h1000);
        for (int k = 0; k < 13; k++)
            queue_req(64'h00000000_80000000, 64'h0, 13'(1 << k));
        queue_req(64'h0, 64'h00000001_80000000, 13'h3);
        queue_req(64'h00000000_FFFFFFFF, 64'hFFFFFFFF_7FFFFFFF, 13'h2);
        queue_req(64'h12345678_9ABCDEF0, 64'h0FEDCBA9_87654321, 13'h1555);
        queue_req(64'h0, 64'hFFFFFFFF, 13'h0AAA);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = phase_pct[ph][0];
            recv_stall_pct = phase_pct[ph][1];
            for (int k = 0; k < 440; k++)
                queue_req(rand64(), rand64(), 13'($urandom));
            while (pending_reqs.size() > 0) @(posedge aclk);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
